[rtl/core/ptc_pkg.sv]
// Shared types and constants for the pressure and temperature compensation block.
package ptc_pkg;

  // Widths of the item fields and the register port
  localparam int RawW   = 20;
  localparam int TempW  = 24;
  localparam int PressW = 32;
  localparam int DataW  = 64;
  localparam int AddrW  = 5;

  // Register map, one 64-bit slot each
  typedef enum logic [1:0] {
    CfgTemp      = 2'd0,
    CfgPressLow  = 2'd1,
    CfgPressHigh = 2'd2,
    CfgPressNine = 2'd3
  } cfg_idx_e;

  // Fixed constants of the compensation formula
  localparam logic signed [63:0] FineOffset = 64'sd128000;
  localparam logic [20:0]        RawFull    = 21'd1048576;
  localparam logic [63:0]        NumScale   = 64'd3125;
  localparam logic signed [63:0] TempRound  = 64'sd128;
  localparam logic signed [63:0] C3Offset   = 64'sd140737488355328;
  localparam logic signed [63:0] TempMax    = 64'sd8388607;
  localparam logic signed [63:0] TempMin    = -64'sd8388608;

  // Data that rides along the whole pipeline
  typedef struct packed {
    logic [TempW-1:0] temp;
    logic [RawW-1:0]  adc_p;
    logic             zero;
  } side_t;

endpackage

[rtl/core/ptc_if.sv]
// Stream interfaces for the raw sample word and the result word.
interface ptc_in_if;
  logic                         valid;
  logic                         ready;
  logic [ptc_pkg::RawW-1:0]     raw_temperature;
  logic [ptc_pkg::RawW-1:0]     raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface ptc_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [ptc_pkg::TempW-1:0] temperature_centi;
  logic [ptc_pkg::PressW-1:0]       pressure_q24_8;
  logic                             pressure_valid;

  modport source (output valid, output temperature_centi, output pressure_q24_8,
                  output pressure_valid, input ready);
  modport sink (input valid, input temperature_centi, input pressure_q24_8,
                input pressure_valid, output ready);
endinterface

[rtl/core/pressure_temperature_compensation.sv]
// Barometric compensation: turns raw temperature and pressure readings into
// hundredths of a degree and pascals times 256 using the standard 64-bit integer
// formula and the twelve calibration words in the register file. The datapath is
// an 83-stage pipeline that takes one word per cycle while the output is not
// stalled. Most of those stages are the 64-bit signed divider, which retires one
// quotient bit per stage; the 64-bit products are two-stage multipliers. A stall
// on the output only halts the stages that are full, so empty slots still fill.
// Calibration registers sit at byte addresses 0, 8, 16 and 24 and should be
// written while no sample is in flight.
module pressure_temperature_compensation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ptc_in_if.sink                       sample_i,
  ptc_out_if.source                    result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptc_pkg::AddrW-1:0]    paddr,
  input  logic [ptc_pkg::DataW-1:0]    pwdata,
  output logic [ptc_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  import ptc_pkg::*;

  localparam int NS = 83;

  // ---------------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------------
  logic [47:0] temp_cal_q;
  logic [63:0] press_lo_q;
  logic [63:0] press_hi_q;
  logic [15:0] press_nine_q;
  cfg_idx_e    cfg_idx;

  assign cfg_idx = cfg_idx_e'(paddr[4:3]);
  assign pready  = 1'b1;

  // Write on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q   <= '0;
      press_lo_q   <= '0;
      press_hi_q   <= '0;
      press_nine_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        CfgTemp:      temp_cal_q   <= pwdata[47:0];
        CfgPressLow:  press_lo_q   <= pwdata;
        CfgPressHigh: press_hi_q   <= pwdata;
        CfgPressNine: press_nine_q <= pwdata[15:0];
        default:      temp_cal_q   <= temp_cal_q;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_idx)
      CfgTemp:      prdata = {16'b0, temp_cal_q};
      CfgPressLow:  prdata = press_lo_q;
      CfgPressHigh: prdata = press_hi_q;
      CfgPressNine: prdata = {48'b0, press_nine_q};
      default:      prdata = '0;
    endcase
  end

  // Calibration words
  logic [15:0]        t1;
  logic signed [15:0] t2;
  logic signed [15:0] t3;
  logic signed [15:0] p2;
  logic signed [15:0] p5;
  logic [63:0]        p1_64;
  logic [63:0]        p3_64;
  logic signed [63:0] p4_64;
  logic [63:0]        p6_64;
  logic signed [63:0] p7_64;
  logic [63:0]        p8_64;
  logic [63:0]        p9_64;

  assign t1    = temp_cal_q[15:0];
  assign t2    = $signed(temp_cal_q[31:16]);
  assign t3    = $signed(temp_cal_q[47:32]);
  assign p1_64 = {48'b0, press_lo_q[15:0]};
  assign p2    = $signed(press_lo_q[31:16]);
  assign p3_64 = {{48{press_lo_q[47]}}, press_lo_q[47:32]};
  assign p4_64 = $signed({{48{press_lo_q[63]}}, press_lo_q[63:48]});
  assign p5    = $signed(press_hi_q[15:0]);
  assign p6_64 = {{48{press_hi_q[31]}}, press_hi_q[31:16]};
  assign p7_64 = $signed({{48{press_hi_q[47]}}, press_hi_q[47:32]});
  assign p8_64 = {{48{press_hi_q[63]}}, press_hi_q[63:48]};
  assign p9_64 = {{48{press_nine_q[15]}}, press_nine_q};

  // ---------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or the next one loads
  // ---------------------------------------------------------------------------
  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = result_o.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign sample_i.ready = rdy[0];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= sample_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Side data line
  side_t side_q [NS];
  side_t side_d [NS];
  logic [TempW-1:0] temp_d;
  logic             div_zero;

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        side_d[k] = '{temp: '0, adc_p: sample_i.raw_pressure, zero: 1'b0};
      end else begin
        side_d[k] = side_q[k-1];
      end
    end
    side_d[3].temp  = temp_d;
    side_d[77].zero = div_zero;
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        side_q[k] <= side_d[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Temperature
  // ---------------------------------------------------------------------------
  logic [RawW-1:0]    adc_t_q;
  logic signed [18:0] xa;
  logic signed [34:0] ax;
  logic signed [17:0] dt;
  logic signed [63:0] a_q;
  logic signed [35:0] ddt_q;
  logic signed [63:0] a2_q;
  logic signed [39:0] b1_q;
  logic signed [23:0] dds;
  logic signed [63:0] fine;
  logic signed [63:0] t5;
  logic signed [63:0] temp64;
  logic signed [63:0] dp_q;

  // Capture the sample
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      adc_t_q <= sample_i.raw_temperature;
    end
  end

  // Linear and square terms of the temperature difference
  assign xa = $signed({2'b00, adc_t_q[19:3]}) - $signed({2'b00, t1, 1'b0});
  assign ax = xa * t2;
  assign dt = $signed({2'b00, adc_t_q[19:4]}) - $signed({2'b00, t1});

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      a_q   <= 64'(ax >>> 11);
      ddt_q <= dt * dt;
    end
  end

  // Scale the square term
  assign dds = 24'(ddt_q >>> 12);

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      a2_q <= a_q;
      b1_q <= dds * t3;
    end
  end

  // Fine temperature, rounded centidegrees, pressure offset
  assign fine   = a2_q + 64'(b1_q >>> 14);
  assign t5     = (fine <<< 2) + fine + TempRound;
  assign temp64 = t5 >>> 8;

  always_comb begin
    if (temp64 > TempMax) begin
      temp_d = TempMax[TempW-1:0];
    end else if (temp64 < TempMin) begin
      temp_d = TempMin[TempW-1:0];
    end else begin
      temp_d = temp64[TempW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      dp_q <= fine - FineOffset;
    end
  end

  // ---------------------------------------------------------------------------
  // Pressure coefficients
  // ---------------------------------------------------------------------------
  logic signed [31:0] dp32;
  logic signed [47:0] dp5w;
  logic signed [47:0] dp2w;
  logic signed [63:0] dd_q;
  logic signed [63:0] dp5_q [3];
  logic signed [63:0] dp2_q [3];
  logic [63:0]        dd6;
  logic [63:0]        dd3;
  logic signed [63:0] c4_q;
  logic signed [63:0] x_q;

  assign dp32 = dp_q[31:0];

  // First-order terms at full product width
  assign dp5w = 48'(dp32) * 48'(p5);
  assign dp2w = 48'(dp32) * 48'(p2);

  // Square the offset and form the first-order terms
  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      dd_q     <= dp32 * dp32;
      dp5_q[0] <= 64'(dp5w);
      dp2_q[0] <= 64'(dp2w);
    end
    if (rdy[5]) begin
      dp5_q[1] <= dp5_q[0];
      dp2_q[1] <= dp2_q[0];
    end
    if (rdy[6]) begin
      dp5_q[2] <= dp5_q[1];
      dp2_q[2] <= dp2_q[1];
    end
  end

  ptc_mul u_mul_dd6 (
    .clk_i (clk_i),
    .en_i  (rdy[6:5]),
    .a_i   (dd_q),
    .b_i   (p6_64),
    .p_o   (dd6)
  );

  ptc_mul u_mul_dd3 (
    .clk_i (clk_i),
    .en_i  (rdy[6:5]),
    .a_i   (dd_q),
    .b_i   (p3_64),
    .p_o   (dd3)
  );

  // Sum the offset and sensitivity terms
  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      c4_q <= $signed(dd6) + (dp5_q[2] <<< 17) + (p4_64 <<< 35);
      x_q  <= ($signed(dd3) >>> 8) + (dp2_q[2] <<< 12) + C3Offset;
    end
  end

  // ---------------------------------------------------------------------------
  // Numerator and divisor
  // ---------------------------------------------------------------------------
  logic [63:0]        pp;
  logic [63:0]        num0;
  logic [63:0]        c3;
  logic [63:0]        nprod;
  logic [63:0]        den_q;
  logic [63:0]        num_q;

  assign pp   = 64'(RawFull - {1'b0, side_q[7].adc_p});
  assign num0 = (pp << 31) - c4_q;

  ptc_mul u_mul_c3 (
    .clk_i (clk_i),
    .en_i  (rdy[9:8]),
    .a_i   (x_q),
    .b_i   (p1_64),
    .p_o   (c3)
  );

  ptc_mul u_mul_num (
    .clk_i (clk_i),
    .en_i  (rdy[9:8]),
    .a_i   (num0),
    .b_i   (NumScale),
    .p_o   (nprod)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[10]) begin
      den_q <= $signed(c3) >>> 33;
      num_q <= nprod;
    end
  end

  // ---------------------------------------------------------------------------
  // Division
  // ---------------------------------------------------------------------------
  logic [63:0] q;

  ptc_div u_div (
    .clk_i  (clk_i),
    .en_i   (rdy[76:11]),
    .num_i  (num_q),
    .den_i  (den_q),
    .q_o    (q),
    .zero_o (div_zero)
  );

  // ---------------------------------------------------------------------------
  // Second-order correction and output
  // ---------------------------------------------------------------------------
  logic signed [63:0] q_q  [3];
  logic signed [63:0] qs_q [3];
  logic [63:0]        e1;
  logic [63:0]        f0;
  logic [63:0]        e2;
  logic signed [63:0] s1_q [2];
  logic signed [63:0] psum;
  logic signed [63:0] pfin;
  logic [PressW-1:0]  press_d;
  logic [PressW-1:0]  press_q;
  logic               pvalid_q;
  logic [TempW-1:0]   temp_q;

  always_ff @(posedge clk_i) begin
    if (rdy[77]) begin
      q_q[0]  <= q;
      qs_q[0] <= $signed(q) >>> 13;
    end
    if (rdy[78]) begin
      q_q[1]  <= q_q[0];
      qs_q[1] <= qs_q[0];
    end
    if (rdy[79]) begin
      q_q[2]  <= q_q[1];
      qs_q[2] <= qs_q[1];
    end
  end

  ptc_mul u_mul_e1 (
    .clk_i (clk_i),
    .en_i  (rdy[79:78]),
    .a_i   (p9_64),
    .b_i   (qs_q[0]),
    .p_o   (e1)
  );

  ptc_mul u_mul_f0 (
    .clk_i (clk_i),
    .en_i  (rdy[79:78]),
    .a_i   (q_q[0]),
    .b_i   (p8_64),
    .p_o   (f0)
  );

  ptc_mul u_mul_e2 (
    .clk_i (clk_i),
    .en_i  (rdy[81:80]),
    .a_i   (e1),
    .b_i   (qs_q[2]),
    .p_o   (e2)
  );

  // Add the linear correction while the square term finishes
  always_ff @(posedge clk_i) begin
    if (rdy[80]) begin
      s1_q[0] <= q_q[2] + ($signed(f0) >>> 19);
    end
    if (rdy[81]) begin
      s1_q[1] <= s1_q[0];
    end
  end

  // Final scale, offset and clamp
  assign psum = s1_q[1] + ($signed(e2) >>> 25);
  assign pfin = (psum >>> 8) + (p7_64 <<< 4);

  always_comb begin
    if (side_q[81].zero) begin
      press_d = '0;
    end else if (pfin[63]) begin
      press_d = '0;
    end else if (pfin[63:32] != 32'd0) begin
      press_d = '1;
    end else begin
      press_d = pfin[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[82]) begin
      press_q  <= press_d;
      pvalid_q <= !side_q[81].zero;
      temp_q   <= side_q[81].temp;
    end
  end

  assign result_o.valid             = v_q[NS-1];
  assign result_o.temperature_centi = $signed(temp_q);
  assign result_o.pressure_q24_8    = press_q;
  assign result_o.pressure_valid    = pvalid_q;

endmodule

[rtl/core/ptc_mul.sv]
// Two-stage 64 x 64 multiplier keeping the low 64 bits of the product.
module ptc_mul (
  input  logic        clk_i,
  input  logic [1:0]  en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_q;
  logic [31:0] lh_q;
  logic [31:0] hl_q;
  logic [63:0] p_q;

  // Form the partial products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ll_q <= a_i[31:0] * b_i[31:0];
      lh_q <= a_i[31:0] * b_i[63:32];
      hl_q <= a_i[63:32] * b_i[31:0];
    end
  end

  // Sum the partial products modulo 2^64
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q <= ll_q + {lh_q + hl_q, 32'b0};
    end
  end

  assign p_o = p_q;

endmodule

[rtl/core/ptc_div.sv]
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
module ptc_div (
  input  logic        clk_i,
  input  logic [65:0] en_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic [63:0] q_o,
  output logic        zero_o
);

  localparam int Steps = 64;

  logic [63:0] n0_q;
  logic [63:0] d0_q;
  logic        neg0_q;
  logic        zero0_q;

  logic [63:0] n_q    [Steps];
  logic [63:0] r_q    [Steps];
  logic [63:0] d_q    [Steps];
  logic        neg_q  [Steps];
  logic        zero_q [Steps];

  logic [63:0] n_in   [Steps];
  logic [63:0] r_in   [Steps];
  logic [63:0] d_in   [Steps];
  logic        neg_in [Steps];
  logic        zero_in[Steps];

  logic [63:0] q_q;
  logic        qz_q;

  // Take magnitudes and the quotient sign
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      n0_q    <= num_i[63] ? (~num_i + 64'd1) : num_i;
      d0_q    <= den_i[63] ? (~den_i + 64'd1) : den_i;
      neg0_q  <= num_i[63] ^ den_i[63];
      zero0_q <= (den_i == 64'd0);
    end
  end

  // Feed each step from the stage before it
  always_comb begin
    for (int i = 0; i < Steps; i++) begin
      if (i == 0) begin
        n_in[i]    = n0_q;
        r_in[i]    = 64'd0;
        d_in[i]    = d0_q;
        neg_in[i]  = neg0_q;
        zero_in[i] = zero0_q;
      end else begin
        n_in[i]    = n_q[i-1];
        r_in[i]    = r_q[i-1];
        d_in[i]    = d_q[i-1];
        neg_in[i]  = neg_q[i-1];
        zero_in[i] = zero_q[i-1];
      end
    end
  end

  // Restoring steps: shift in one dividend bit, subtract when it fits
  for (genvar g = 0; g < Steps; g++) begin : g_step
    logic [64:0] rr;
    logic        ge;
    assign rr = {r_in[g], n_in[g][63]};
    assign ge = (rr >= {1'b0, d_in[g]});

    always_ff @(posedge clk_i) begin
      if (en_i[g+1]) begin
        r_q[g]    <= ge ? 64'(rr - {1'b0, d_in[g]}) : rr[63:0];
        n_q[g]    <= {n_in[g][62:0], ge};
        d_q[g]    <= d_in[g];
        neg_q[g]  <= neg_in[g];
        zero_q[g] <= zero_in[g];
      end
    end
  end

  // Apply the sign to the quotient
  always_ff @(posedge clk_i) begin
    if (en_i[65]) begin
      q_q  <= neg_q[Steps-1] ? (~n_q[Steps-1] + 64'd1) : n_q[Steps-1];
      qz_q <= zero_q[Steps-1];
    end
  end

  assign q_o    = q_q;
  assign zero_o = qz_q;

endmodule
